// ===== rtl/prd_pkg.sv =====
package prd_pkg;

   // Field and register widths
   localparam int SAMPLE_BITS = 18;
   localparam int FRAC_BITS   = 16;
   localparam int IR_W        = 18;
   localparam int COEF_W      = 16;
   localparam int OFFSET_W    = 18;
   localparam int WINDOW_W    = 8;
   localparam int MULT_W      = 4;
   localparam int STATE_W     = 40;
   localparam int LEVEL_W     = 22;
   localparam int COUNT_W     = 8;
   localparam int RATE_W      = 12;
   localparam int TICK_W      = 8;

   // Datapath widths
   localparam int DIFF_W      = STATE_W + 2;
   localparam int SUM_W       = DIFF_W + 2;
   localparam int CHUNK_LO_W  = 22;
   localparam int CHUNK_HI_W  = DIFF_W - CHUNK_LO_W;
   localparam int MUL_A_W     = COEF_W + 1;
   localparam int MUL_B_W     = CHUNK_LO_W + 1;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int ACC_W       = MUL_A_W + CHUNK_HI_W + CHUNK_LO_W;
   localparam int LVL_RAW_W   = STATE_W - FRAC_BITS;

   // Configuration port
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_W   = CSR_ADDR_W - 2;

   localparam logic [COEF_W-1:0]   DC_ALPHA_RST     = 16'd58982;
   localparam logic [COEF_W-1:0]   SMOOTH_ALPHA_RST = 16'd3277;
   localparam logic [OFFSET_W-1:0] LEVEL_OFFSET_RST = 18'd2500;
   localparam logic [WINDOW_W-1:0] WINDOW_LIMIT_RST = 8'd10;
   localparam logic [MULT_W-1:0]   RATE_MULT_RST    = 4'd6;

   localparam logic [STATE_W-1:0]  STATE_MAX = {STATE_W{1'b1}};
   localparam logic [LEVEL_W-1:0]  LEVEL_MAX = {LEVEL_W{1'b1}};
   localparam logic [COUNT_W-1:0]  COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DC_ALPHA,
      CSR_SMOOTH_ALPHA,
      CSR_LEVEL_OFFSET,
      CSR_WINDOW_LIMIT,
      CSR_RATE_MULT
   } csr_idx_type;

   typedef struct packed {
      logic [COEF_W-1:0]   dc_alpha_q16;
      logic [COEF_W-1:0]   smooth_alpha_q16;
      logic [OFFSET_W-1:0] level_offset;
      logic [WINDOW_W-1:0] window_limit;
      logic [MULT_W-1:0]   rate_multiplier;
   } cfg_type;

   // Microcode
   localparam int UPC_W = 3;

   typedef enum logic [2:0] {
      UOP_MUL_LO,
      UOP_MUL_HI,
      UOP_DC_SUM,
      UOP_DIFF,
      UOP_SMOOTH,
      UOP_TICK
   } uop_type;

   typedef enum logic {
      MSRC_DC,
      MSRC_DIFF
   } msrc_type;

   typedef enum logic {
      JMP_NONE,
      JMP_TICK
   } jcond_type;

   typedef struct packed {
      uop_type           uop;
      msrc_type          msrc;
      jcond_type         jcond;
      logic [UPC_W-1:0]  jaddr;
      logic              last;
   } ucode_type;

   localparam logic [UPC_W-1:0] TICK_ENTRY = 3'd7;

   typedef struct packed {
      logic     step_en;
      logic     last;
      uop_type  uop;
      msrc_type msrc;
   } ctrl_type;

   typedef struct packed {
      logic               rate_valid;
      logic [RATE_W-1:0]  rate;
      logic [LEVEL_W-1:0] level;
      logic [COUNT_W-1:0] pulse_count;
      logic               armed;
   } res_type;

   typedef enum logic {
      PULSE_LOW,
      PULSE_HIGH
   } pulse_state_type;

   // Sample program: two partial products for the DC feedback, the DC sum,
   // the difference, two partial products for the smoother, the smoother
   // update. A tick leaves the first step for the tick entry.
   function automatic ucode_type ucode_word(input logic [UPC_W-1:0] pc);
      ucode_type w;
      w = '{uop: UOP_TICK, msrc: MSRC_DC, jcond: JMP_NONE, jaddr: '0, last: 1'b1};
      case (pc)
         3'd0: w = '{uop: UOP_MUL_LO, msrc: MSRC_DC, jcond: JMP_TICK,
                     jaddr: TICK_ENTRY, last: 1'b0};
         3'd1: w = '{uop: UOP_MUL_HI, msrc: MSRC_DC, jcond: JMP_NONE,
                     jaddr: '0, last: 1'b0};
         3'd2: w = '{uop: UOP_DC_SUM, msrc: MSRC_DC, jcond: JMP_NONE,
                     jaddr: '0, last: 1'b0};
         3'd3: w = '{uop: UOP_DIFF, msrc: MSRC_DC, jcond: JMP_NONE,
                     jaddr: '0, last: 1'b0};
         3'd4: w = '{uop: UOP_MUL_LO, msrc: MSRC_DIFF, jcond: JMP_NONE,
                     jaddr: '0, last: 1'b0};
         3'd5: w = '{uop: UOP_MUL_HI, msrc: MSRC_DIFF, jcond: JMP_NONE,
                     jaddr: '0, last: 1'b0};
         3'd6: w = '{uop: UOP_SMOOTH, msrc: MSRC_DIFF, jcond: JMP_NONE,
                     jaddr: '0, last: 1'b1};
         default: w = '{uop: UOP_TICK, msrc: MSRC_DC, jcond: JMP_NONE,
                        jaddr: '0, last: 1'b1};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/prd_req_if.sv =====
interface prd_req_if import prd_pkg::*; ();
   logic            valid;
   logic            ready;
   logic            cmd;
   logic [IR_W-1:0] ir_sample;
   logic            active;

   modport source (output valid, output cmd, output ir_sample, output active,
                   input ready);
   modport sink   (input valid, input cmd, input ir_sample, input active,
                   output ready);
endinterface

// ===== rtl/prd_rsp_if.sv =====
interface prd_rsp_if import prd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               rate_valid;
   logic [RATE_W-1:0]  rate;
   logic [LEVEL_W-1:0] level;
   logic [COUNT_W-1:0] pulse_count;
   logic               armed;

   modport source (output valid, output rate_valid, output rate, output level,
                   output pulse_count, output armed, input ready);
   modport sink   (input valid, input rate_valid, input rate, input level,
                   input pulse_count, input armed, output ready);
endinterface

// ===== rtl/prd_csr.sv =====
module prd_csr import prd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type     cfg_ff, cfg_in;
   csr_idx_type idx;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign idx        = csr_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            CSR_DC_ALPHA:     cfg_in.dc_alpha_q16     = csr_pwdata[COEF_W-1:0];
            CSR_SMOOTH_ALPHA: cfg_in.smooth_alpha_q16 = csr_pwdata[COEF_W-1:0];
            CSR_LEVEL_OFFSET: cfg_in.level_offset     = csr_pwdata[OFFSET_W-1:0];
            CSR_WINDOW_LIMIT: cfg_in.window_limit     = csr_pwdata[WINDOW_W-1:0];
            CSR_RATE_MULT:    cfg_in.rate_multiplier  = csr_pwdata[MULT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (idx)
         CSR_DC_ALPHA:     csr_prdata = CSR_DATA_W'(cfg_ff.dc_alpha_q16);
         CSR_SMOOTH_ALPHA: csr_prdata = CSR_DATA_W'(cfg_ff.smooth_alpha_q16);
         CSR_LEVEL_OFFSET: csr_prdata = CSR_DATA_W'(cfg_ff.level_offset);
         CSR_WINDOW_LIMIT: csr_prdata = CSR_DATA_W'(cfg_ff.window_limit);
         CSR_RATE_MULT:    csr_prdata = CSR_DATA_W'(cfg_ff.rate_multiplier);
         default:          csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dc_alpha_q16     <= DC_ALPHA_RST;
         cfg_ff.smooth_alpha_q16 <= SMOOTH_ALPHA_RST;
         cfg_ff.level_offset     <= LEVEL_OFFSET_RST;
         cfg_ff.window_limit     <= WINDOW_LIMIT_RST;
         cfg_ff.rate_multiplier  <= RATE_MULT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/prd_useq.sv =====
module prd_useq import prd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  logic     start_tick,
   input  logic     stall,
   output logic     busy,
   output ctrl_type ctrl
);

   logic             busy_ff, busy_in;
   logic [UPC_W-1:0] pc_ff, pc_in;
   logic             tick_ff, tick_in;
   ucode_type        word;
   logic             step_en;

   assign word    = ucode_word(pc_ff);
   // hold the closing step while the result register is still occupied
   assign step_en = busy_ff && !(word.last && stall);
   assign busy    = busy_ff;

   assign ctrl.step_en = step_en;
   assign ctrl.last    = word.last;
   assign ctrl.uop     = word.uop;
   assign ctrl.msrc    = word.msrc;

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      tick_in = tick_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = '0;
         tick_in = start_tick;
      end else if (step_en) begin
         if (word.last) begin
            busy_in = 1'b0;
         end else if (word.jcond == JMP_TICK && tick_ff) begin
            pc_in = word.jaddr;
         end else begin
            pc_in = pc_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= '0;
         tick_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
         tick_ff <= tick_in;
      end
   end

   a_last_ends : assert property (@(posedge clock) disable iff (reset)
      step_en && word.last && !start |=> !busy_ff)
      else $error("closing step did not end the item");

   a_tick_jump : assert property (@(posedge clock) disable iff (reset)
      step_en && tick_ff && pc_ff == '0 |=> pc_ff == TICK_ENTRY)
      else $error("tick item did not branch to tick entry");

endmodule

// ===== rtl/prd_datapath.sv =====
module prd_datapath import prd_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [IR_W-1:0] start_sample,
   input  logic            start_active,
   input  cfg_type         cfg,
   input  ctrl_type        ctrl,
   output res_type         res
);

   // item latch
   logic [SAMPLE_BITS-1:0]  x_ff;
   logic                    active_ff;

   // scratch
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [STATE_W-1:0]       w_ff, w_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;

   // filter and counter state
   logic [STATE_W-1:0]  dc_prev_ff, dc_prev_in;
   logic [STATE_W-1:0]  smooth_ff, smooth_in;
   pulse_state_type     pulse_ff, pulse_in;
   logic                just_ret_ff, just_ret_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                armed_ff, armed_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;

   // shared multiplier
   logic [DIFF_W-1:0]          src;
   logic [COEF_W-1:0]          coef;
   logic signed [MUL_A_W-1:0]  mul_a;
   logic signed [MUL_B_W-1:0]  mul_b;
   logic signed [PROD_W-1:0]   prod;
   logic signed [ACC_W-1:0]    acc_sh;

   logic [DIFF_W-1:0]         dc_sum;
   logic signed [SUM_W-1:0]   sm_sum;
   logic [STATE_W-1:0]        s_new;
   logic                      lvl_nz;
   logic                      sample_commit;
   logic                      tick_commit;
   logic                      bump;
   logic [COUNT_W-1:0]        count_bumped;
   logic [TICK_W:0]           tick_next;
   logic [RATE_W-1:0]         rate_prod;
   logic                      rate_fire;

   assign src   = (ctrl.msrc == MSRC_DC) ? DIFF_W'(dc_prev_ff) : diff_ff;
   assign coef  = (ctrl.msrc == MSRC_DC) ? cfg.dc_alpha_q16 : cfg.smooth_alpha_q16;
   assign mul_a = $signed({1'b0, coef});
   assign mul_b = (ctrl.uop == UOP_MUL_HI) ?
                  MUL_B_W'($signed(src[DIFF_W-1:CHUNK_LO_W])) :
                  $signed({1'b0, src[CHUNK_LO_W-1:0]});
   assign prod  = mul_a * mul_b;

   // floor of the product sum over the Q16 coefficient scale
   assign acc_sh = acc_ff >>> COEF_W;

   assign dc_sum = (DIFF_W'(x_ff) << FRAC_BITS) + acc_sh[DIFF_W-1:0];

   // (65536-a)*s + a*y over 2^16 is s + floor(a*(y-s) / 2^16)
   assign sm_sum = $signed(SUM_W'(smooth_ff)) + acc_sh[SUM_W-1:0]
                   - $signed(SUM_W'(cfg.level_offset) << FRAC_BITS);

   always_comb begin
      if (sm_sum[SUM_W-1]) begin
         s_new = '0;
      end else if (|sm_sum[SUM_W-2:STATE_W]) begin
         s_new = STATE_MAX;
      end else begin
         s_new = sm_sum[STATE_W-1:0];
      end
   end

   assign lvl_nz        = |s_new[STATE_W-1:FRAC_BITS];
   assign sample_commit = ctrl.step_en && ctrl.uop == UOP_SMOOTH;
   assign tick_commit   = ctrl.step_en && ctrl.uop == UOP_TICK;

   always_comb begin
      acc_in     = acc_ff;
      w_in       = w_ff;
      diff_in    = diff_ff;
      dc_prev_in = dc_prev_ff;
      smooth_in  = smooth_ff;
      if (ctrl.step_en) begin
         case (ctrl.uop)
            UOP_MUL_LO: acc_in = ACC_W'(prod);
            UOP_MUL_HI: acc_in = acc_ff + (ACC_W'(prod) <<< CHUNK_LO_W);
            UOP_DC_SUM: w_in = (|dc_sum[DIFF_W-1:STATE_W]) ? STATE_MAX
                                                            : dc_sum[STATE_W-1:0];
            UOP_DIFF: begin
               diff_in    = $signed(DIFF_W'(dc_prev_ff)) - $signed(DIFF_W'(w_ff))
                            - $signed(DIFF_W'(smooth_ff));
               dc_prev_in = w_ff;
            end
            UOP_SMOOTH: smooth_in = s_new;
            default:    acc_in = acc_ff;
         endcase
      end
   end

   // pulse detector: next state
   always_comb begin
      pulse_in = pulse_ff;
      if (sample_commit) begin
         case (pulse_ff)
            PULSE_LOW:  if (lvl_nz) pulse_in = PULSE_HIGH;
            PULSE_HIGH: if (!lvl_nz) pulse_in = PULSE_LOW;
            default:    pulse_in = PULSE_LOW;
         endcase
      end
   end

   // pulse detector: outputs
   always_comb begin
      bump        = 1'b0;
      just_ret_in = just_ret_ff;
      if (sample_commit) begin
         case (pulse_ff)
            PULSE_LOW: begin
               bump        = just_ret_ff;
               just_ret_in = 1'b0;
            end
            PULSE_HIGH: if (!lvl_nz) just_ret_in = 1'b1;
            default:    just_ret_in = 1'b0;
         endcase
      end
   end

   assign count_bumped = count_ff + COUNT_W'(bump && count_ff != COUNT_MAX);
   assign tick_next    = {1'b0, tick_ff} + 1'b1;
   assign rate_fire    = tick_commit && armed_ff &&
                         tick_next > {1'b0, cfg.window_limit};
   // 255 * 15 stays below the 12-bit ceiling, so no clamp is needed
   assign rate_prod    = RATE_W'(count_ff) * RATE_W'(cfg.rate_multiplier);

   always_comb begin
      count_in = count_ff;
      armed_in = armed_ff;
      tick_in  = tick_ff;
      if (sample_commit) begin
         if (count_bumped != '0 && active_ff) begin
            armed_in = 1'b1;
            count_in = count_bumped;
         end else begin
            armed_in = 1'b0;
            count_in = '0;
         end
      end else if (tick_commit && armed_ff) begin
         if (rate_fire) begin
            tick_in  = '0;
            count_in = '0;
            armed_in = 1'b0;
         end else begin
            tick_in = tick_next[TICK_W-1:0];
         end
      end
   end

   assign res.rate_valid  = rate_fire;
   assign res.rate        = rate_fire ? rate_prod : '0;
   assign res.level       = (|smooth_in[STATE_W-1:FRAC_BITS+LEVEL_W]) ? LEVEL_MAX
                            : smooth_in[FRAC_BITS+LEVEL_W-1:FRAC_BITS];
   assign res.pulse_count = count_in;
   assign res.armed       = armed_in;

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff      <= start_sample[SAMPLE_BITS-1:0];
         active_ff <= start_active;
      end
      acc_ff  <= acc_in;
      w_ff    <= w_in;
      diff_ff <= diff_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dc_prev_ff  <= '0;
         smooth_ff   <= '0;
         pulse_ff    <= PULSE_LOW;
         just_ret_ff <= 1'b0;
         count_ff    <= '0;
         armed_ff    <= 1'b0;
         tick_ff     <= '0;
      end else begin
         dc_prev_ff  <= dc_prev_in;
         smooth_ff   <= smooth_in;
         pulse_ff    <= pulse_in;
         just_ret_ff <= just_ret_in;
         count_ff    <= count_in;
         armed_ff    <= armed_in;
         tick_ff     <= tick_in;
      end
   end

   a_armed_count : assert property (@(posedge clock) disable iff (reset)
      armed_ff |-> count_ff != '0)
      else $error("armed with an empty pulse count");

   a_rate_on_tick : assert property (@(posedge clock) disable iff (reset)
      res.rate_valid |-> ctrl.step_en && ctrl.uop == UOP_TICK)
      else $error("rate reported outside a tick step");

endmodule

// ===== rtl/pulse_rate_detector_unit.sv =====
// A sample transaction runs the sample program through the smoother update, a tick
// branches to the tick entry; a new one is taken only once the sequencer is idle.
// The shared 17x23 multiplier runs two partial products per filter product.
// The closing step holds while the result register is still occupied.
// Reset (synchronous, active high) clears filter state, counters, the sequencer
// and the result register, and loads the default configuration.
module pulse_rate_detector_unit import prd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   prd_req_if.sink               req_ch,
   prd_rsp_if.source             rsp_ch,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type  cfg;
   ctrl_type ctrl;
   res_type  res;
   logic     busy;
   logic     start;
   logic     stall;
   logic     done;

   logic     rsp_valid_ff, rsp_valid_in;
   res_type  rsp_data_ff, rsp_data_in;

   // One transaction at a time: take a new one only when the sequencer is idle.
   assign req_ch.ready = !busy;
   assign start        = req_ch.valid && !busy;

   // Hold the final step while an earlier result has not been taken.
   assign stall = rsp_valid_ff && !rsp_ch.ready;
   assign done  = ctrl.step_en && ctrl.last;

   prd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Microcode sequencer: step counter, control ROM, tick branch.
   prd_useq u_useq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .start_tick (req_ch.cmd),
      .stall      (stall),
      .busy       (busy),
      .ctrl       (ctrl)
   );

   // Datapath: shared multiplier, accumulator, filters, pulse counter.
   prd_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .start_sample (req_ch.ir_sample),
      .start_active (req_ch.active),
      .cfg          (cfg),
      .ctrl         (ctrl),
      .res          (res)
   );

   // Result register: load on the closing step, drop once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.rate_valid  = rsp_data_ff.rate_valid;
   assign rsp_ch.rate        = rsp_data_ff.rate;
   assign rsp_ch.level       = rsp_data_ff.level;
   assign rsp_ch.pulse_count = rsp_data_ff.pulse_count;
   assign rsp_ch.armed       = rsp_data_ff.armed;

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      done |-> !(rsp_valid_ff && !rsp_ch.ready))
      else $error("result register overwritten before it was taken");

   a_done_fills : assert property (@(posedge clock) disable iff (reset)
      done |=> rsp_valid_ff)
      else $error("closing step did not fill the result register");

endmodule

// ===== sim/tb.sv =====
module tb;
   import prd_pkg::*;

   // Item kinds carried on the cmd field
   typedef enum logic {
      CMD_SAMPLE,
      CMD_TICK
   } cmd_type;

   localparam int IR_MAX     = (1 << IR_W) - 1;
   // Settle time after a drain, with margin over the time a sample takes to finish
   localparam int SETTLE_CYC = 16;
   localparam logic [WINDOW_W-1:0] WINDOW_LIMIT_MAX = {WINDOW_W{1'b1}};

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   prd_req_if req_bus ();
   prd_rsp_if rsp_bus ();

   pulse_rate_detector_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Free-running clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor state: a private copy of the filter state, the pulse
   // counter and the register file, updated once per accepted transaction.
   // ------------------------------------------------------------------
   cfg_type            regs;
   logic [STATE_W-1:0] dc_hist;       // previous DC-removal output w
   logic [STATE_W-1:0] smooth_acc;    // smoothed, offset-clamped level
   pulse_state_type    pulse_st;
   logic               returned_low;  // a nonzero run has just ended
   logic [COUNT_W-1:0] beat_count;
   logic               window_open;
   logic [TICK_W-1:0]  seconds;

   res_type pending_readings[$];      // expected results, oldest first

   int send_gap_pct;                  // chance in percent that the sender idles a cycle
   int recv_stall_pct;                // chance in percent that the receiver stalls a cycle
   int items_sent;
   int readings_checked;
   int mismatches;

   // Compute the result of one transaction and advance the predictor state.
   function automatic res_type next_reading(input cmd_type c, input logic [IR_W-1:0] x,
                                            input logic act);
      res_type              r;
      longint               w;
      longint               y;
      longint               t;
      longint               s;
      logic [LVL_RAW_W-1:0] lvl;
      logic [TICK_W:0]      sec_next;
      r = '0;
      if (c == CMD_SAMPLE) begin
         // DC removal: w = x + a*w_prev, saturating; y = w_prev - w, signed
         w = (longint'(x) <<< FRAC_BITS)
             + ((longint'(regs.dc_alpha_q16) * longint'(dc_hist)) >>> COEF_W);
         if (w > longint'(STATE_MAX)) w = longint'(STATE_MAX);
         y = longint'(dc_hist) - w;
         dc_hist = w[STATE_W-1:0];
         // Smoother with the offset taken off inside the recurrence;
         // the arithmetic shift floors negative sums
         t = longint'(regs.smooth_alpha_q16) * y
             + ((longint'(1) <<< COEF_W) - longint'(regs.smooth_alpha_q16))
               * longint'(smooth_acc);
         s = (t >>> COEF_W) - (longint'(regs.level_offset) <<< FRAC_BITS);
         if (s < 0) s = 0;
         if (s > longint'(STATE_MAX)) s = longint'(STATE_MAX);
         smooth_acc = s[STATE_W-1:0];
         lvl = smooth_acc[STATE_W-1:FRAC_BITS];

         // Count a pulse on the first sample after a nonzero run returns to zero
         if (pulse_st == PULSE_LOW) begin
            if (returned_low && beat_count != COUNT_MAX) beat_count = beat_count + 1'b1;
            returned_low = 1'b0;
            if (lvl != '0) pulse_st = PULSE_HIGH;
         end else if (lvl == '0) begin
            returned_low = 1'b1;
            pulse_st = PULSE_LOW;
         end

         // Disarm clears the count but leaves the seconds counter alone
         if (beat_count != '0 && act) begin
            window_open = 1'b1;
         end else begin
            window_open = 1'b0;
            beat_count = '0;
         end
      end else if (window_open) begin
         // Compare with one extra bit so that a limit of 255 closes on tick 256
         sec_next = {1'b0, seconds} + 1'b1;
         if (sec_next > {1'b0, regs.window_limit}) begin
            r.rate_valid = 1'b1;
            r.rate = RATE_W'(beat_count) * RATE_W'(regs.rate_multiplier);
            seconds = '0;
            beat_count = '0;
            window_open = 1'b0;
         end else begin
            seconds = sec_next[TICK_W-1:0];
         end
      end
      // Ticks report the stored level untouched
      lvl = smooth_acc[STATE_W-1:FRAC_BITS];
      r.level = (lvl > LEVEL_MAX) ? LEVEL_MAX : lvl[LEVEL_W-1:0];
      r.pulse_count = beat_count;
      r.armed = window_open;
      return r;
   endfunction

   // Mirror one register write; indexes off the list are dropped
   function automatic void apply_register(input logic [CSR_IDX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_DC_ALPHA:     regs.dc_alpha_q16     = value[COEF_W-1:0];
         CSR_SMOOTH_ALPHA: regs.smooth_alpha_q16 = value[COEF_W-1:0];
         CSR_LEVEL_OFFSET: regs.level_offset     = value[OFFSET_W-1:0];
         CSR_WINDOW_LIMIT: regs.window_limit     = value[WINDOW_W-1:0];
         CSR_RATE_MULT:    regs.rate_multiplier  = value[MULT_W-1:0];
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------
   task automatic flag_mismatch(input string msg);
      $display("MISMATCH at result %0d: %s", readings_checked, msg);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   // Compare every accepted result with the oldest expectation
   always @(posedge clock) begin : result_check
      res_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_readings.size() == 0) begin
            flag_mismatch($sformatf("result with nothing expected, level %0d", rsp_bus.level));
         end else begin
            want = pending_readings.pop_front();
            compare_field("rate_valid", 32'(rsp_bus.rate_valid), 32'(want.rate_valid));
            compare_field("rate", 32'(rsp_bus.rate), 32'(want.rate));
            compare_field("level", 32'(rsp_bus.level), 32'(want.level));
            compare_field("pulse_count", 32'(rsp_bus.pulse_count), 32'(want.pulse_count));
            compare_field("armed", 32'(rsp_bus.armed), 32'(want.armed));
         end
         readings_checked++;
      end
   end

   // Stall the result channel at random; one assignment per falling edge
   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ------------------------------------------------------------------
   // Stimulus helpers (entered and left at a falling edge)
   // ------------------------------------------------------------------

   // Send one transaction: idle at random, hold valid until ready, then
   // record the expectation. Valid stays high so back-to-back items flow.
   task automatic send_item(input cmd_type c, input logic [IR_W-1:0] x, input logic act);
      while ($urandom_range(99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.cmd       <= c;
      req_bus.ir_sample <= x;
      req_bus.active    <= act;
      do @(posedge clock); while (!req_bus.ready);
      pending_readings.push_back(next_reading(c, x, act));
      items_sent++;
      @(negedge clock);
   endtask

   // Drop valid and hold off until every expected result has come back
   task automatic drain_readings();
      req_bus.valid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   // Two-phase register write: setup, then access; written at the access edge
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      apply_register(idx, value);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // Reprogram every register once the block has gone idle
   task automatic set_registers(input logic [CSR_DATA_W-1:0] dc_alpha,
                                input logic [CSR_DATA_W-1:0] smooth_alpha,
                                input logic [CSR_DATA_W-1:0] offset,
                                input logic [CSR_DATA_W-1:0] win,
                                input logic [CSR_DATA_W-1:0] mult);
      drain_readings();
      csr_write(CSR_DC_ALPHA, dc_alpha);
      csr_write(CSR_SMOOTH_ALPHA, smooth_alpha);
      csr_write(CSR_LEVEL_OFFSET, offset);
      csr_write(CSR_WINDOW_LIMIT, win);
      csr_write(CSR_RATE_MULT, mult);
   endtask

   // High/low sample pairs: with no DC feedback and a fast smoother each
   // drop makes a nonzero run and the next rise ends it, one pulse per pair.
   task automatic send_beats(input int pairs, input logic act);
      repeat (pairs) begin
         send_item(CMD_SAMPLE, IR_W'($urandom_range(IR_MAX / 2 + 1024, IR_MAX)), act);
         send_item(CMD_SAMPLE, IR_W'($urandom_range(0, IR_MAX / 2)), act);
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Reset values: extreme samples, a tick while not armed
   task automatic test_default_registers();
      send_item(CMD_SAMPLE, '0, 1'b0);
      send_item(CMD_TICK, '0, 1'b0);
      send_item(CMD_SAMPLE, IR_W'(IR_MAX), 1'b1);
      send_item(CMD_SAMPLE, '0, 1'b1);
   endtask

   // Full-scale DC feedback, frozen smoother, largest offset, and writes to
   // addresses past the register list, which must change nothing
   task automatic test_register_extremes();
      set_registers(CSR_DATA_W'({COEF_W{1'b1}}), '0, CSR_DATA_W'({OFFSET_W{1'b1}}),
                    CSR_DATA_W'({WINDOW_W{1'b1}}), CSR_DATA_W'({MULT_W{1'b1}}));
      for (int i = CSR_RATE_MULT + 1; i < (1 << CSR_IDX_W); i++)
         csr_write(CSR_IDX_W'(i), $urandom);
      send_item(CMD_SAMPLE, IR_W'(IR_MAX), 1'b1);
      send_item(CMD_SAMPLE, '0, 1'b1);
      send_item(CMD_TICK, IR_W'(IR_MAX), 1'b1);
   endtask

   // Window of zero, multiplier of zero and fifteen, and a disarm that
   // keeps the seconds counter
   task automatic test_window_rules();
      set_registers('0, CSR_DATA_W'({COEF_W{1'b1}}), '0, '0, '0);
      send_beats(2, 1'b1);
      send_item(CMD_TICK, '0, 1'b1);
      set_registers('0, CSR_DATA_W'({COEF_W{1'b1}}), '0, '0, CSR_DATA_W'({MULT_W{1'b1}}));
      send_beats(1, 1'b1);
      send_item(CMD_TICK, '0, 1'b1);
      set_registers('0, CSR_DATA_W'({COEF_W{1'b1}}), '0, 3, 4);
      send_beats(1, 1'b1);
      send_item(CMD_TICK, '0, 1'b1);
      send_item(CMD_SAMPLE, IR_W'(IR_MAX), 1'b0);
      send_item(CMD_SAMPLE, '0, 1'b1);
      repeat (3) send_item(CMD_TICK, '0, 1'b1);
   endtask

   // Saturate the pulse count, then run the widest window to its close
   task automatic test_saturation_limits();
      set_registers('0, CSR_DATA_W'({COEF_W{1'b1}}), '0, CSR_DATA_W'({WINDOW_W{1'b1}}),
                    CSR_DATA_W'({MULT_W{1'b1}}));
      send_beats(int'(COUNT_MAX) + 3, 1'b1);
      repeat (int'(WINDOW_LIMIT_MAX) + 1) send_item(CMD_TICK, IR_W'($urandom), 1'b1);
   endtask

   // Mostly well-formed pulse shapes with random amplitude, some noise,
   // and now and then a full drain so the block runs dry mid-traffic
   task automatic test_random_traffic(input int count);
      int start;
      int kind;
      int base;
      int amp;
      logic act;
      start = items_sent;
      while (items_sent - start < count) begin
         kind = $urandom_range(99);
         if (kind < 80) begin
            base = $urandom_range(0, IR_MAX / 2);
            amp  = $urandom_range(64, IR_MAX - base);
            act  = ($urandom_range(31) != 0);
            repeat ($urandom_range(1, 3))
               send_item(CMD_SAMPLE, IR_W'(base + amp - $urandom_range(0, amp / 8)), act);
            send_item(CMD_SAMPLE, IR_W'(base), act);
            repeat ($urandom_range(1, 3))
               send_item(CMD_SAMPLE, IR_W'(base + $urandom_range(0, amp)), act);
            if ($urandom_range(2) == 0) send_item(CMD_TICK, IR_W'($urandom), act);
         end else if (kind < 97) begin
            send_item(cmd_type'($urandom_range(1)), IR_W'($urandom), 1'($urandom_range(1)));
         end else begin
            drain_readings();
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = 1'b0;
      req_bus.ir_sample = '0;
      req_bus.active    = 1'b0;
      rsp_bus.ready     = 1'b0;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;

      regs.dc_alpha_q16     = DC_ALPHA_RST;
      regs.smooth_alpha_q16 = SMOOTH_ALPHA_RST;
      regs.level_offset     = LEVEL_OFFSET_RST;
      regs.window_limit     = WINDOW_LIMIT_RST;
      regs.rate_multiplier  = RATE_MULT_RST;
      dc_hist          = '0;
      smooth_acc       = '0;
      pulse_st         = PULSE_LOW;
      returned_low     = 1'b0;
      beat_count       = '0;
      window_open      = 1'b0;
      seconds          = '0;
      items_sent       = 0;
      readings_checked = 0;
      mismatches       = 0;

      // Sender rarely idles, receiver mostly stalls
      send_gap_pct   = 6;
      recv_stall_pct = 69;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_registers();
      test_register_extremes();
      test_window_rules();
      set_registers('0, CSR_DATA_W'({COEF_W{1'b1}}), '0, 1, CSR_DATA_W'({MULT_W{1'b1}}));
      test_random_traffic(180);

      // Swap: sender mostly idles, receiver rarely stalls
      send_gap_pct   = 69;
      recv_stall_pct = 6;
      test_saturation_limits();
      set_registers($urandom_range(0, 40000), $urandom_range(30000, 65535),
                    $urandom_range(0, 300), $urandom_range(2, 12), $urandom_range(1, 15));
      test_random_traffic(180);

      // Full rate on both sides
      send_gap_pct   = 0;
      recv_stall_pct = 0;
      set_registers($urandom, $urandom_range(8192, 65535), $urandom_range(0, 1023),
                    $urandom_range(0, 15), $urandom);
      test_random_traffic(180);

      // Drain, then give stray results time to show up
      drain_readings();
      repeat (SETTLE_CYC) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog: a hung handshake or a lost result ends here
   initial begin
      #4_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
